// ===== rtl/atpr_pkg.sv =====
// ----------------------------------------------------------------------------
// atpr_pkg: shared types and constants
// Beat payload types, fixed-point widths, configuration register indexes
// and the CORDIC arctangent table for the tilt angle projection core.
// ----------------------------------------------------------------------------
package atpr_pkg;

  // Beat payloads
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } atpr_in_t;

  typedef struct packed {
    logic        angle_negative;
    logic [6:0]  angle_whole;
    logic [6:0]  angle_hundredths;
    logic        length_negative;
    logic [14:0] length_whole;
    logic [6:0]  length_hundredths;
  } atpr_out_t;

  // Stage handoff control
  typedef struct packed {
    logic valid;
  } atpr_ctrl_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = 2'd1;
  localparam int CFG_DATA_W = 16;

  // Fixed-point widths
  localparam int SQ_W   = 48;  // radicand (x^2 + z^2) << 16
  localparam int ROOT_W = 24;  // radius, Q.8
  localparam int AT_W   = 27;  // arctangent CORDIC x / y
  localparam int ANG_W  = 25;  // Q8.16 degrees, signed
  localparam int SN_W   = 33;  // sine CORDIC x / y, Q2.30
  localparam int SIN_W  = 32;  // clamped sine
  localparam int LEN_W  = 48;  // length product, Q.30 cm

  localparam logic signed [ANG_W-1:0] DEG90_Q16  = 25'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180_Q16 = 25'sd11796480;
  localparam logic signed [SN_W-1:0]  SIN_ONE    = 33'sd1073741824;
  localparam logic signed [SN_W-1:0]  CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [ANG_W-1:0] OFFSET_RESET_Q16 = 25'sd131072;
  localparam logic signed [10:0]      OFFSET_RESET = 11'sd200;

  // Reciprocal of 100 for values below 2^16: (v * RECIP_100) >> 24
  localparam logic [17:0] RECIP_100 = 18'd167773;

  // atan(2^-i) in Q8.16 degrees
  function automatic logic [21:0] atan_q16(input logic [4:0] idx);
    logic [21:0] r;
    case (idx)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/atpr_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// atpr_sqrt_cell: one digit of the pipelined integer square root
// Tries one result bit at a fixed weight and hands remainder, partial root
// and side data to the next cell.
// ----------------------------------------------------------------------------
module atpr_sqrt_cell import atpr_pkg::*; #(
  parameter int BIT_POS = 0,
  parameter int SIDE_W  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  atpr_ctrl_t        ctrl_i,
  input  logic [SQ_W-1:0]   rem_i,
  input  logic [SQ_W-1:0]   root_i,
  input  logic [SIDE_W-1:0] side_i,
  output atpr_ctrl_t        ctrl_o,
  output logic [SQ_W-1:0]   rem_o,
  output logic [SQ_W-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam logic [SQ_W-1:0] BitVal = SQ_W'(1) << BIT_POS;

  logic [SQ_W-1:0] trial;
  logic [SQ_W-1:0] rem_d, root_d;
  atpr_ctrl_t      ctrl_q;
  logic [SQ_W-1:0] rem_q, root_q;
  logic [SIDE_W-1:0] side_q;

  // Subtract the trial value when it fits
  always_comb begin
    trial = root_i + BitVal;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + BitVal;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

// ===== rtl/atpr_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// atpr_cordic_cell: one CORDIC micro-rotation
// Vectoring or rotation mode, fixed shift, table angle from the package.
// ----------------------------------------------------------------------------
module atpr_cordic_cell import atpr_pkg::*; #(
  parameter int XW      = 27,
  parameter int SHIFT   = 0,
  parameter bit VECTOR  = 1'b1,
  parameter int SIDE_W  = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  atpr_ctrl_t              ctrl_i,
  input  logic signed [XW-1:0]    x_i,
  input  logic signed [XW-1:0]    y_i,
  input  logic signed [ANG_W-1:0] z_i,
  input  logic [SIDE_W-1:0]       side_i,
  output atpr_ctrl_t              ctrl_o,
  output logic signed [XW-1:0]    x_o,
  output logic signed [XW-1:0]    y_o,
  output logic signed [ANG_W-1:0] z_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam logic signed [ANG_W-1:0] Step = ANG_W'(atan_q16(5'(SHIFT)));

  logic signed [XW-1:0]    dx, dy, x_d, y_d;
  logic signed [ANG_W-1:0] z_d;
  logic                    turn_cw;
  atpr_ctrl_t              ctrl_q;
  logic signed [XW-1:0]    x_q, y_q;
  logic signed [ANG_W-1:0] z_q;
  logic [SIDE_W-1:0]       side_q;

  // Rotate by the table angle in the direction that drives y or z to zero
  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    turn_cw = VECTOR ? (y_i >= 0) : (z_i < 0);
    if (turn_cw) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = VECTOR ? (z_i + Step) : (z_i + Step);
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - Step;
    end
  end

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

// ===== rtl/accel_tilt_angle_projection_core.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angle_projection_core: tilt angle and projected length
// Square-root, arctangent and sine chains of cells with an output register.
// ----------------------------------------------------------------------------
// One sample enters per cycle and passes through the input register,
// squaring, 24 square-root cells, CORDIC_STAGES arctangent cells, offset
// and fold, CORDIC_STAGES sine cells, length multiply and output split.
// The whole chain advances together and holds while a finished result
// waits on out_ready_i, so throughput is one beat per cycle whenever the
// sink takes results. Configuration writes are taken in every cycle; a new
// angle offset is held in off_q and converted into off_q16_q before use.
module accel_tilt_angle_projection_core import atpr_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  atpr_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output atpr_out_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NSq = ROOT_W;

  logic adv;

  // Configuration registers
  logic [14:0]              arm_q;
  logic signed [10:0]       off_q;
  logic signed [ANG_W-1:0]  off_q16_q;
  logic [10:0]              off_mag;
  logic [19:0]              off_whole;
  logic [15:0]              off_part;
  logic [33:0]              off_prod;
  logic [ANG_W-1:0]         off_conv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q     <= '0;
      off_q     <= OFFSET_RESET;
      off_q16_q <= OFFSET_RESET_Q16;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_ARM_LENGTH) begin
        arm_q <= cfg_data_i[14:0];
      end
      if (cfg_valid_i && cfg_index_i == CFG_ANGLE_OFFSET) begin
        off_q <= $signed(cfg_data_i[10:0]);
      end
      off_q16_q <= off_q[10] ? -$signed(off_conv) : $signed(off_conv);
    end
  end

  // Convert centidegrees to Q8.16: m*655 + floor((m*36 + 50) / 100)
  always_comb begin
    off_mag   = off_q[10] ? 11'(-off_q) : 11'(off_q);
    off_whole = 20'(off_mag) * 20'd655;
    off_part  = 16'(off_mag) * 16'd36 + 16'd50;
    off_prod  = 34'(off_part) * 34'(RECIP_100);
    off_conv  = ANG_W'(off_whole) + ANG_W'(off_prod[33:24]);
  end

  // Chain advances when the output register is free or being drained
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Input register
  atpr_ctrl_t        c0_q;
  logic signed [15:0] x0_q, y0_q, z0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q <= '0;
    end else if (adv) begin
      c0_q.valid <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q <= in_data_i.accel_x;
      y0_q <= in_data_i.accel_y;
      z0_q <= in_data_i.accel_z;
    end
  end

  // Square the horizontal axes
  atpr_ctrl_t         c1_q;
  logic [31:0]        xx_q, zz_q;
  logic signed [15:0] y1_q;
  logic               zero1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
    end else if (adv) begin
      c1_q <= c0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xx_q    <= $unsigned(32'(x0_q * x0_q));
      zz_q    <= $unsigned(32'(z0_q * z0_q));
      y1_q    <= y0_q;
      zero1_q <= (x0_q == 16'sd0) && (z0_q == 16'sd0);
    end
  end

  // Square-root chain; side carries the zero flag and y
  atpr_ctrl_t      sq_c    [0:NSq];
  logic [SQ_W-1:0] sq_rem  [0:NSq];
  logic [SQ_W-1:0] sq_root [0:NSq];
  logic [16:0]     sq_side [0:NSq];

  assign sq_c[0]    = c1_q;
  assign sq_rem[0]  = {xx_q + zz_q, 16'd0};
  assign sq_root[0] = '0;
  assign sq_side[0] = {zero1_q, y1_q};

  for (genvar k = 0; k < NSq; k++) begin : g_sqrt
    atpr_sqrt_cell #(
      .BIT_POS (SQ_W - 2 - 2 * k),
      .SIDE_W  (17)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctrl_i (sq_c[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .ctrl_o (sq_c[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // Arctangent chain; side carries zero flag, y sign, y nonzero
  atpr_ctrl_t              at_c    [0:CORDIC_STAGES];
  logic signed [AT_W-1:0]  at_x    [0:CORDIC_STAGES];
  logic signed [AT_W-1:0]  at_y    [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0] at_z    [0:CORDIC_STAGES];
  logic [2:0]              at_side [0:CORDIC_STAGES];
  logic signed [15:0]      sq_y;

  assign sq_y       = $signed(sq_side[NSq][15:0]);
  assign at_c[0]    = sq_c[NSq];
  assign at_x[0]    = $signed({3'b000, sq_root[NSq][ROOT_W-1:0]});
  assign at_y[0]    = $signed({{3{sq_y[15]}}, sq_y, 8'd0});
  assign at_z[0]    = '0;
  assign at_side[0] = {sq_side[NSq][16], sq_y[15], sq_y != 16'sd0};

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_atan
    atpr_cordic_cell #(
      .XW     (AT_W),
      .SHIFT  (k),
      .VECTOR (1'b1),
      .SIDE_W (3)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctrl_i (at_c[k]),
      .x_i    (at_x[k]),
      .y_i    (at_y[k]),
      .z_i    (at_z[k]),
      .side_i (at_side[k]),
      .ctrl_o (at_c[k+1]),
      .x_o    (at_x[k+1]),
      .y_o    (at_y[k+1]),
      .z_o    (at_z[k+1]),
      .side_o (at_side[k+1])
    );
  end

  // Pick the vertical special case, add the offset, fold into [-90, 90]
  logic [2:0]              at_fl;
  logic signed [ANG_W-1:0] raw_ang, ang_d, fold_d;
  atpr_ctrl_t              c2_q;
  logic signed [ANG_W-1:0] ang2_q, fold2_q;

  always_comb begin
    at_fl = at_side[CORDIC_STAGES];
    if (at_fl[2]) begin
      if (!at_fl[0]) begin
        raw_ang = '0;
      end else if (at_fl[1]) begin
        raw_ang = -DEG90_Q16;
      end else begin
        raw_ang = DEG90_Q16;
      end
    end else begin
      raw_ang = at_z[CORDIC_STAGES];
    end
    ang_d = raw_ang + off_q16_q;
    if (ang_d > DEG90_Q16) begin
      fold_d = DEG180_Q16 - ang_d;
    end else if (ang_d < -DEG90_Q16) begin
      fold_d = -DEG180_Q16 - ang_d;
    end else begin
      fold_d = ang_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q <= '0;
    end else if (adv) begin
      c2_q <= at_c[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang2_q  <= ang_d;
      fold2_q <= fold_d;
    end
  end

  // Sine chain; side carries the tilt angle
  atpr_ctrl_t              sn_c    [0:CORDIC_STAGES];
  logic signed [SN_W-1:0]  sn_x    [0:CORDIC_STAGES];
  logic signed [SN_W-1:0]  sn_y    [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0] sn_z    [0:CORDIC_STAGES];
  logic [ANG_W-1:0]        sn_side [0:CORDIC_STAGES];

  assign sn_c[0]    = c2_q;
  assign sn_x[0]    = CORDIC_GAIN_Q30;
  assign sn_y[0]    = '0;
  assign sn_z[0]    = fold2_q;
  assign sn_side[0] = ang2_q;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_sin
    atpr_cordic_cell #(
      .XW     (SN_W),
      .SHIFT  (k),
      .VECTOR (1'b0),
      .SIDE_W (ANG_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctrl_i (sn_c[k]),
      .x_i    (sn_x[k]),
      .y_i    (sn_y[k]),
      .z_i    (sn_z[k]),
      .side_i (sn_side[k]),
      .ctrl_o (sn_c[k+1]),
      .x_o    (sn_x[k+1]),
      .y_o    (sn_y[k+1]),
      .z_o    (sn_z[k+1]),
      .side_o (sn_side[k+1])
    );
  end

  // Clamp the sine and scale by the arm length
  logic signed [SN_W-1:0]  sn_out;
  logic signed [SIN_W-1:0] sin_sat;
  logic signed [15:0]      arm_s;
  atpr_ctrl_t              c3_q;
  logic signed [LEN_W-1:0] len3_q;
  logic signed [ANG_W-1:0] ang3_q;

  always_comb begin
    sn_out = sn_y[CORDIC_STAGES];
    if (sn_out > SIN_ONE) begin
      sin_sat = SIN_W'(SIN_ONE);
    end else if (sn_out < -SIN_ONE) begin
      sin_sat = SIN_W'(-SIN_ONE);
    end else begin
      sin_sat = SIN_W'(sn_out);
    end
    arm_s = $signed({1'b0, arm_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
    end else if (adv) begin
      c3_q <= sn_c[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len3_q <= LEN_W'(arm_s * sin_sat);
      ang3_q <= $signed(sn_side[CORDIC_STAGES]);
    end
  end

  // Split both values into sign, whole part and truncated hundredths
  logic [ANG_W-1:0] a_mag;
  logic [8:0]       a_whole;
  logic [22:0]      a_hund;
  logic [LEN_W-1:0] l_mag;
  logic [17:0]      l_whole;
  logic [36:0]      l_hund;
  atpr_out_t        res_d;
  logic             out_valid_q;
  atpr_out_t        out_q;

  always_comb begin
    a_mag   = ang3_q[ANG_W-1] ? ANG_W'(-ang3_q) : ANG_W'(ang3_q);
    a_whole = a_mag[ANG_W-1:16];
    a_hund  = 23'(a_mag[15:0]) * 23'd100;
    l_mag   = len3_q[LEN_W-1] ? LEN_W'(-len3_q) : LEN_W'(len3_q);
    l_whole = l_mag[LEN_W-1:30];
    l_hund  = 37'(l_mag[29:0]) * 37'd100;

    res_d.angle_negative    = ang3_q[ANG_W-1];
    res_d.angle_whole       = (a_whole > 9'd127) ? 7'd127 : a_whole[6:0];
    res_d.angle_hundredths  = a_hund[22:16];
    res_d.length_negative   = len3_q[LEN_W-1];
    res_d.length_whole      = (l_whole > 18'd32767) ? 15'd32767 : l_whole[14:0];
    res_d.length_hundredths = l_hund[36:30];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= c3_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/atpr_checker.sv =====
// ----------------------------------------------------------------------------
// atpr_checker: port-level checks for the tilt angle projection core
// Watches the top-level ports and is attached by a bind below.
// ----------------------------------------------------------------------------
module atpr_checker import atpr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input atpr_out_t             out_data_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Input side stalls exactly when a result is held
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not track output stall");

  // A result appears only after the pipeline advanced
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result beat without pipeline advance");

  // Hundredths stay in range
  a_hund_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.angle_hundredths <= 7'd99) &&
                    (out_data_o.length_hundredths <= 7'd99))
    else $error("hundredths out of range");

endmodule

bind accel_tilt_angle_projection_core atpr_checker u_atpr_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: tilt angle projection core regression
// Drives accelerometer samples through the valid/ready input port, predicts
// the tilt angle and projected length for each accepted sample and checks
// every result beat in order. Covers several register settings, random
// idling on both sides and a long output stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module testbench;
  import atpr_pkg::*;

  localparam int STAGES    = 16;
  localparam int LATENCY   = 2 * STAGES + 29;
  localparam int MAX_CYC   = 400000;
  localparam int STALL_LEN = 300;

  localparam longint ATAN_TBL [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  atpr_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  atpr_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_ARM_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  accel_tilt_angle_projection_core #(.CORDIC_STAGES(STAGES)) dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow registers and expected results
  longint     arm_len_sh;
  longint     offset_sh;
  atpr_out_t  tilt_exp_q[$];
  int         errors = 0;
  int         results_seen = 0;
  int         samples_sent = 0;
  int         cycles = 0;
  bit         idle_on = 1'b1;
  bit         stall_req = 1'b0;
  int         stall_left = 0;
  int         idle_left = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > n) bits >>= 2;
    while (bits != 0) begin
      if (n >= res + bits) begin
        n -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic int n_stages();
    return (STAGES < 32) ? STAGES : 32;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < n_stages(); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic longint rotate_sine(longint a);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    if (a > 5898240) a = 11796480 - a;
    else if (a < -5898240) a = -11796480 - a;
    z = a;
    for (int i = 0; i < n_stages(); i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    if (y > 1073741824) y = 1073741824;
    if (y < -1073741824) y = -1073741824;
    return y;
  endfunction

  // Split a fixed-point value into sign, clamped whole part and hundredths
  function automatic void split_fixed(longint v, int fb, longint unsigned wmax,
                                      output logic neg, output longint unsigned whole,
                                      output longint unsigned hund);
    longint unsigned mag, w;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    w = mag >> fb;
    neg = (v < 0);
    whole = (w > wmax) ? wmax : w;
    hund = (((mag & ((64'd1 << fb) - 1)) * 100) >> fb) & 64'h7f;
  endfunction

  function automatic atpr_out_t tilt_predict(atpr_in_t s);
    longint ax, ay, az, ang, off, len;
    longint unsigned offmag, wh, hu;
    logic ng;
    atpr_out_t r;
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    if (ax == 0 && az == 0) begin
      ang = (ay > 0) ? 5898240 : ((ay < 0) ? -5898240 : 0);
    end else begin
      ang = vector_angle(longint'(int_sqrt(longint'(ax * ax + az * az) << 16)), ay * 256);
    end
    offmag = (offset_sh < 0) ? -offset_sh : offset_sh;
    offmag = (offmag * 65536 + 50) / 100;
    off = (offset_sh < 0) ? -longint'(offmag) : longint'(offmag);
    ang += off;
    len = arm_len_sh * rotate_sine(ang);
    split_fixed(ang, 16, 127, ng, wh, hu);
    r.angle_negative = ng;
    r.angle_whole = wh[6:0];
    r.angle_hundredths = hu[6:0];
    split_fixed(len, 30, 32767, ng, wh, hu);
    r.length_negative = ng;
    r.length_whole = wh[14:0];
    r.length_hundredths = hu[6:0];
    return r;
  endfunction

  task automatic report_field(string name, longint got, longint want);
    if (got != want) begin
      errors++;
      $display("mismatch beat %0d %s: got %0d want %0d", results_seen, name, got, want);
    end
  endtask

  // Output side: random idle bursts, long hold-off on request
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
    if (stall_req) begin
      stall_req = 1'b0;
      stall_left = STALL_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && idle_left > 0) begin
      idle_left--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      idle_left = $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check each accepted result beat against the oldest expectation
  always @(posedge clk_i) begin
    atpr_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tilt_exp_q.size() == 0) begin
        errors++;
        $display("unexpected result beat %0d", results_seen);
      end else begin
        want = tilt_exp_q.pop_front();
        report_field("angle_negative", out_data_o.angle_negative, want.angle_negative);
        report_field("angle_whole", out_data_o.angle_whole, want.angle_whole);
        report_field("angle_hundredths", out_data_o.angle_hundredths,
                     want.angle_hundredths);
        report_field("length_negative", out_data_o.length_negative, want.length_negative);
        report_field("length_whole", out_data_o.length_whole, want.length_whole);
        report_field("length_hundredths", out_data_o.length_hundredths,
                     want.length_hundredths);
      end
      results_seen++;
    end
  end

  // Send one sample, with an optional idle burst ahead of it
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    atpr_in_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tilt_exp_q.push_back(tilt_predict(s));
    samples_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tilt_exp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write one register while the pipeline is empty
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint val);
    logic [CFG_DATA_W-1:0] d;
    drain();
    d = val[15:0];
    if (idx == CFG_ANGLE_OFFSET) d[15:11] = 5'($urandom);
    else d[15] = 1'($urandom);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_ARM_LENGTH) arm_len_sh = d[14:0];
    else offset_sh = longint'($signed(d[10:0]));
    repeat (3) @(posedge clk_i);
  endtask

  task automatic send_random();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) send_sample(16'd0, 16'($urandom), 16'd0);
    else if (kind == 1) send_sample(16'($signed($urandom_range(0, 8)) - 4),
                                    16'($urandom), 16'($signed($urandom_range(0, 8)) - 4));
    else if (kind == 2) send_sample(16'($urandom), 16'($signed($urandom_range(0, 64)) - 32),
                                    16'($urandom));
    else send_sample(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    logic [15:0] ext [4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 16'd100, 16'd0);
    send_sample(16'd0, 16'hff9c, 16'd0);
    send_sample(16'd0, 16'h8000, 16'd0);
    send_sample(16'd0, 16'h7fff, 16'd0);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_sample(ext[i], ext[j], ext[(i + j) % 4]);
    send_sample(16'd1, 16'hffff, 16'd0);
    send_sample(16'd1000, 16'd0, 16'd0);
    drain();
  endtask

  task automatic test_settings();
    longint lens [4] = '{0, 32767, 1, 12345};
    longint offs [4] = '{-1000, 1000, 0, -1};
    for (int k = 0; k < 4; k++) begin
      cfg_write(CFG_ARM_LENGTH, lens[k]);
      cfg_write(CFG_ANGLE_OFFSET, offs[k]);
      send_sample(16'd0, 16'd0, 16'd0);
      send_sample(16'd0, 16'h7fff, 16'd0);
      send_sample(16'd0, 16'h8000, 16'd0);
      repeat (100) send_random();
    end
    for (int k = 0; k < 2; k++) begin
      cfg_write(CFG_ARM_LENGTH, $urandom_range(0, 32767));
      cfg_write(CFG_ANGLE_OFFSET, longint'($urandom_range(0, 2000)) - 1000);
      repeat (100) send_random();
    end
  endtask

  task automatic test_backpressure();
    stall_req = 1'b1;
    repeat (LATENCY + 60) send_random();
    drain();
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    cfg_write(CFG_ARM_LENGTH, 32767);
    cfg_write(CFG_ANGLE_OFFSET, 1000);
    repeat (100) send_random();
    drain();
  endtask

  initial begin
    arm_len_sh = 0;
    offset_sh = 200;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    test_backpressure();
    test_full_rate();
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("covered %0d samples, %0d results, six register settings, long output stall",
             samples_sent, results_seen);
    if (errors == 0 && tilt_exp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, tilt_exp_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
